@@ design/bctd_pkg.sv @@
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types, constants and divide helpers for the texture block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bctd_pkg;

  localparam int MAX_DIM_BLOCKS = 1024;
  localparam int DIM_W          = $clog2(MAX_DIM_BLOCKS);
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int PIX_W          = 12;
  localparam int PIX_PER_BLOCK  = 16;
  localparam int PIX_CNT_W      = $clog2(PIX_PER_BLOCK);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_DXTA = 2'd3
  } fmt_t;

  // classified block, front to back
  typedef struct packed {
    fmt_t                  fmt;
    logic [31:0]           cidx;
    logic [63:0]           aword;
    logic [2:0][7:0]       p0;
    logic [2:0][7:0]       p1;
    logic [2:0][9:0]       s2;
    logic [2:0][9:0]       s3;
    logic [2:0][8:0]       avg;
    logic                  punch;
    logic                  mode7;
    logic [5:0][10:0]      asum;
    logic [DIM_W-1:0]      col;
    logic [DIM_W-1:0]      row;
    logic                  image_end;
  } job_t;

  // resolved palettes of the block being streamed
  typedef struct packed {
    fmt_t                  fmt;
    logic [31:0]           cidx;
    logic [63:0]           aword;
    logic [3:0][2:0][7:0]  rgb;
    logic                  punch;
    logic [7:0][7:0]       apal;
    logic [DIM_W-1:0]      col;
    logic [DIM_W-1:0]      row;
    logic                  image_end;
  } pal_t;

  // floor(x / 3) for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(683);
    return p[18:11];
  endfunction

  // floor(x / 5) for x up to 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(1639);
    return p[20:13];
  endfunction

  // floor(x / 7) for x up to 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(4682);
    return p[22:15];
  endfunction

endpackage

`default_nettype wire

@@ design/bctd_ifs.sv @@
// ----------------------------------------------------------------------------
// bctd_ifs
// Handshake channels: compressed block in, pixel out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bctd_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] first_half;
  logic [63:0] second_half;

  modport source (output valid, first_half, second_half, input ready);
  modport sink   (input valid, first_half, second_half, output ready);
endinterface

interface bctd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  logic [7:0]                  alpha;
  logic [bctd_pkg::PIX_W-1:0]  pixel_x;
  logic [bctd_pkg::PIX_W-1:0]  pixel_y;
  logic                        last_of_block;
  logic                        last_of_image;

  modport source (output valid, red, green, blue, alpha, pixel_x, pixel_y,
                  last_of_block, last_of_image, input ready);
  modport sink   (input valid, red, green, blue, alpha, pixel_x, pixel_y,
                  last_of_block, last_of_image, output ready);
endinterface

interface bctd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bctd_pkg::CFG_IDX_W-1:0]  index;
  logic [bctd_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/bctd_front.sv @@
// ----------------------------------------------------------------------------
// bctd_front
// Register file, block position counter and endpoint/weight preparation.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  bctd_blk_if.sink           src,
  bctd_cfg_if.sink           cfg,
  output bctd_pkg::job_t     job,
  output logic               job_valid,
  input  wire logic          job_ready
);

  bctd_pkg::fmt_t                   texture_format;
  logic [bctd_pkg::CFG_W-1:0]       width_blocks;
  logic [bctd_pkg::CFG_W-1:0]       height_blocks;
  logic [bctd_pkg::DIM_W-1:0]       block_column;
  logic [bctd_pkg::DIM_W-1:0]       block_row;
  logic [bctd_pkg::CFG_W-1:0]       wdec;
  logic [bctd_pkg::CFG_W-1:0]       hdec;
  logic [bctd_pkg::DIM_W-1:0]       wm1;
  logic [bctd_pkg::DIM_W-1:0]       hm1;
  logic                             row_end;
  logic                             col_last;
  logic                             accept;

  assign cfg.ready = !rst;
  assign src.ready = job_ready && !rst;
  assign job_valid = src.valid && !rst;
  assign accept    = src.valid && src.ready;

  // effective dimension minus one, zero acts as one, oversize saturates
  always_comb begin
    wdec = width_blocks - bctd_pkg::CFG_W'(1);
    hdec = height_blocks - bctd_pkg::CFG_W'(1);
    if (width_blocks == '0) begin
      wm1 = '0;
    end else if (width_blocks > bctd_pkg::CFG_W'(bctd_pkg::MAX_DIM_BLOCKS)) begin
      wm1 = bctd_pkg::DIM_W'(bctd_pkg::MAX_DIM_BLOCKS - 1);
    end else begin
      wm1 = wdec[bctd_pkg::DIM_W-1:0];
    end
    if (height_blocks == '0) begin
      hm1 = '0;
    end else if (height_blocks > bctd_pkg::CFG_W'(bctd_pkg::MAX_DIM_BLOCKS)) begin
      hm1 = bctd_pkg::DIM_W'(bctd_pkg::MAX_DIM_BLOCKS - 1);
    end else begin
      hm1 = hdec[bctd_pkg::DIM_W-1:0];
    end
  end

  assign row_end  = block_column >= wm1;
  assign col_last = block_row >= hm1;

  always_comb begin
    logic [31:0]      cword;
    logic [15:0]      e0;
    logic [15:0]      e1;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [10:0]      s7;
    logic [10:0]      s5;
    cword = (texture_format == bctd_pkg::FMT_DXT1) ? src.first_half[31:0]
                                                   : src.second_half[31:0];
    job.cidx = (texture_format == bctd_pkg::FMT_DXT1) ? src.first_half[63:32]
                                                      : src.second_half[63:32];
    e0 = cword[15:0];
    e1 = cword[31:16];
    job.fmt   = texture_format;
    job.aword = src.first_half;
    job.punch = (texture_format == bctd_pkg::FMT_DXT1) && (e0 <= e1);
    job.p0[0] = {e0[4:0], 3'b000};
    job.p0[1] = {e0[10:5], 2'b00};
    job.p0[2] = {e0[15:11], 3'b000};
    job.p1[0] = {e1[4:0], 3'b000};
    job.p1[1] = {e1[10:5], 2'b00};
    job.p1[2] = {e1[15:11], 3'b000};
    for (int c = 0; c < 3; c++) begin
      job.s2[c]  = {1'b0, job.p0[c], 1'b0} + 10'(job.p1[c]);
      job.s3[c]  = 10'(job.p0[c]) + {1'b0, job.p1[c], 1'b0};
      job.avg[c] = 9'(job.p0[c]) + 9'(job.p1[c]);
    end
    a0 = src.first_half[7:0];
    a1 = src.first_half[15:8];
    job.mode7 = a0 > a1;
    for (int z = 0; z < 6; z++) begin
      s7 = 11'(6 - z) * 11'(a0) + 11'(z + 1) * 11'(a1);
      s5 = (z < 4) ? (11'(4 - z) * 11'(a0) + 11'(z + 1) * 11'(a1)) : '0;
      job.asum[z] = job.mode7 ? s7 : s5;
    end
    job.col       = block_column;
    job.row       = block_row;
    job.image_end = row_end && col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= bctd_pkg::FMT_DXT1;
      width_blocks   <= bctd_pkg::CFG_W'(1);
      height_blocks  <= bctd_pkg::CFG_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bctd_pkg::REG_FORMAT: texture_format <= bctd_pkg::fmt_t'(cfg.data[1:0]);
        bctd_pkg::REG_WIDTH:  width_blocks   <= cfg.data;
        bctd_pkg::REG_HEIGHT: height_blocks  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      if (row_end) begin
        block_column <= '0;
        block_row    <= col_last ? '0 : block_row + bctd_pkg::DIM_W'(1);
      end else begin
        block_column <= block_column + bctd_pkg::DIM_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bctd_queue.sv @@
// ----------------------------------------------------------------------------
// bctd_queue
// Short request queue between the front and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  bctd_pkg::job_t     in_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  output bctd_pkg::job_t     out_data,
  output logic               out_valid,
  input  wire logic          out_ready
);

  bctd_pkg::job_t                store [bctd_pkg::QUEUE_DEPTH];
  logic [bctd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bctd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bctd_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  function automatic logic [bctd_pkg::QPTR_W-1:0] advance(
    input logic [bctd_pkg::QPTR_W-1:0] p
  );
    return (p == bctd_pkg::QPTR_W'(bctd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                              : p + bctd_pkg::QPTR_W'(1);
  endfunction

  assign in_ready  = count != bctd_pkg::QCNT_W'(bctd_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = store[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + bctd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bctd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/bctd_back.sv @@
// ----------------------------------------------------------------------------
// bctd_back
// Palette resolution and pixel sequencer, one pixel a cycle to the output while dst is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  bctd_pkg::job_t     job,
  input  wire logic          job_valid,
  output logic               job_ready,
  bctd_pix_if.source         dst
);

  bctd_pkg::pal_t                  pal;
  bctd_pkg::pal_t                  pal_next;
  logic                            pal_valid;
  logic [bctd_pkg::PIX_CNT_W-1:0]  pix;
  logic                            emit;
  logic                            last_pix;
  logic                            pop;
  logic                            out_valid;

  logic [1:0]                      ci;
  logic [5:0]                      aoff;
  logic [3:0]                      nib;
  logic [7:0]                      av;
  logic [7:0]                      r;
  logic [7:0]                      g;
  logic [7:0]                      b;
  logic [7:0]                      a;

  assign last_pix  = pix == bctd_pkg::PIX_CNT_W'(bctd_pkg::PIX_PER_BLOCK - 1);
  assign emit      = pal_valid && (!out_valid || dst.ready);
  assign job_ready = !pal_valid || (emit && last_pix);
  assign pop       = job_valid && job_ready;
  assign dst.valid = out_valid;

  // palettes from the prepared weighted sums
  always_comb begin
    pal_next.fmt       = job.fmt;
    pal_next.cidx      = job.cidx;
    pal_next.aword     = job.aword;
    pal_next.punch     = job.punch;
    pal_next.col       = job.col;
    pal_next.row       = job.row;
    pal_next.image_end = job.image_end;
    for (int c = 0; c < 3; c++) begin
      pal_next.rgb[0][c] = job.p0[c];
      pal_next.rgb[1][c] = job.p1[c];
      pal_next.rgb[2][c] = job.punch ? job.avg[c][8:1] : bctd_pkg::div3(job.s2[c]);
      pal_next.rgb[3][c] = job.punch ? 8'd0 : bctd_pkg::div3(job.s3[c]);
    end
    pal_next.apal[0] = job.aword[7:0];
    pal_next.apal[1] = job.aword[15:8];
    for (int z = 0; z < 6; z++) begin
      if (job.mode7) begin
        pal_next.apal[z + 2] = bctd_pkg::div7(job.asum[z]);
      end else if (z < 4) begin
        pal_next.apal[z + 2] = bctd_pkg::div5(job.asum[z]);
      end else if (z == 4) begin
        pal_next.apal[z + 2] = 8'd0;
      end else begin
        pal_next.apal[z + 2] = bctd_pkg::ALPHA_OPAQUE;
      end
    end
  end

  // pixel selection
  always_comb begin
    ci   = pal.cidx[{pix, 1'b0} +: 2];
    aoff = 6'({pix, 1'b0}) + 6'(pix) + 6'(16);
    nib  = pal.aword[{pix, 2'b00} +: 4];
    av   = pal.apal[pal.aword[aoff +: 3]];
    r    = pal.rgb[ci][0];
    g    = pal.rgb[ci][1];
    b    = pal.rgb[ci][2];
    a    = bctd_pkg::ALPHA_OPAQUE;
    unique case (pal.fmt)
      bctd_pkg::FMT_DXT1: a = (pal.punch && ci == 2'd3) ? 8'd0 : bctd_pkg::ALPHA_OPAQUE;
      bctd_pkg::FMT_DXT3: a = {nib, nib};
      bctd_pkg::FMT_DXT5: a = av;
      bctd_pkg::FMT_DXTA: begin
        r = av;
        g = av;
        b = av;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pal <= pal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= 1'b0;
      pix       <= '0;
      out_valid <= 1'b0;
    end else begin
      pal_valid <= pop || (pal_valid && !(emit && last_pix));
      if (emit) begin
        pix <= pix + bctd_pkg::PIX_CNT_W'(1);
      end
      out_valid <= emit || (out_valid && !dst.ready);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      dst.red           <= r;
      dst.green         <= g;
      dst.blue          <= b;
      dst.alpha         <= a;
      dst.pixel_x       <= bctd_pkg::PIX_W'({pal.col, pix[1:0]});
      dst.pixel_y       <= bctd_pkg::PIX_W'({pal.row, pix[3:2]});
      dst.last_of_block <= last_pix;
      dst.last_of_image <= last_pix && pal.image_end;
    end
  end

endmodule

`default_nettype wire

@@ design/bc_texture_block_decoder.sv @@
// ----------------------------------------------------------------------------
// bc_texture_block_decoder
// Decodes one DXT1/DXT3/DXT5/DXTA block per request into 16 RGBA pixels.
// The sequencer sends one pixel a cycle to dst while dst is ready.
// A two-entry queue lets up to two further blocks be taken while one streams.
// Reset: format DXT1, dimensions one block, position and queue cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_texture_block_decoder (
  input  wire logic    clk,
  input  wire logic    rst,
  bctd_blk_if.sink     src,
  bctd_pix_if.source   dst,
  bctd_cfg_if.sink     cfg
);

  bctd_pkg::job_t  front_job;
  logic            front_valid;
  logic            front_ready;
  bctd_pkg::job_t  back_job;
  logic            back_valid;
  logic            back_ready;

  bctd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src       (src),
    .cfg       (cfg),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  bctd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (front_job),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_data  (back_job),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  bctd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .dst       (dst)
  );

endmodule

`default_nettype wire

@@ bench/tb_bc_texture_block_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_bc_texture_block_decoder
// Self-checking bench for the texture block decoder. A short table of
// directed blocks covers the extremes of each format, then phases of random
// blocks under random format and image sizes. Every request is decoded by a
// behavioural pixel predictor, and each pixel out is compared field by field
// with the oldest predicted one. Both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bc_texture_block_decoder;

  localparam logic [bctd_pkg::CFG_IDX_W-1:0] REG_SPARE = bctd_pkg::CFG_IDX_W'(3);
  localparam int N_DIR = 21;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic [7:0]                 alpha;
    logic [bctd_pkg::PIX_W-1:0] px;
    logic [bctd_pkg::PIX_W-1:0] py;
    logic                       last_blk;
    logic                       last_img;
  } pixel_t;

  typedef struct packed {
    bctd_pkg::fmt_t             fmt;
    logic [bctd_pkg::CFG_W-1:0] wdt;
    logic [bctd_pkg::CFG_W-1:0] hgt;
    logic [63:0]                fh;
    logic [63:0]                sh;
    logic                       typed;
    logic [31:0]                rgba;
  } block_row_t;

  localparam block_row_t BLOCK_TABLE [N_DIR] = '{
    '{bctd_pkg::FMT_DXT1, 11'd1, 11'd1, 64'h0, 64'h0, 1'b1, 32'h000000FF},
    '{bctd_pkg::FMT_DXT1, 11'd1, 11'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'h00000000},
    '{bctd_pkg::FMT_DXT1, 11'd1, 11'd1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b1, 32'hF8FCF8FF},
    '{bctd_pkg::FMT_DXT1, 11'd1, 11'd1, 64'hE4E4_E4E4_1234_F81F, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT1, 11'd3, 11'd2, 64'h1B1B_1B1B_F81F_1234, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT1, 11'd3, 11'd2, 64'hA5A5_5A5A_7BEF_7BEF, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT3, 11'd3, 11'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'h000000FF},
    '{bctd_pkg::FMT_DXT3, 11'd3, 11'd2, 64'h0, 64'hE4E4_E4E4_0000_FFFF, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT3, 11'd3, 11'd2, 64'h0123_4567_89AB_CDEF, 64'h1B1B_1B1B_FFFF_0000,
      1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT5, 11'd3, 11'd2, 64'h0000_0000_0000_00FF, 64'h0, 1'b1, 32'h000000FF},
    '{bctd_pkg::FMT_DXT5, 11'd3, 11'd2, 64'hFAC6_88FA_C688_30C8, 64'h3C3C_3C3C_07E0_F800,
      1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT5, 11'd3, 11'd2, 64'hFAC6_88FA_C688_D020, 64'hC3C3_3C3C_F800_07E0,
      1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT5, 11'd3, 11'd2, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 1'b1, 32'h000000FF},
    '{bctd_pkg::FMT_DXT5, 11'd3, 11'd2, 64'hDB6D_B6DB_6DB6_8080, 64'h0, 1'b1, 32'h00000000},
    '{bctd_pkg::FMT_DXTA, 11'd3, 11'd2, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b1, 32'hFFFFFFFF},
    '{bctd_pkg::FMT_DXTA, 11'd3, 11'd2, 64'hFAC6_88FA_C688_05FA, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXTA, 11'd3, 11'd2, 64'hFAC6_88FA_C688_FF00, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT1, 11'd2047, 11'd0, 64'h9E37_79B9_7F4A_7C15, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT1, 11'd2047, 11'd0, 64'hC2B2_AE3D_27D4_EB4F, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT1, 11'd1, 11'd1, 64'h1656_67B1_9E37_79F9, 64'h0, 1'b0, 32'h0},
    '{bctd_pkg::FMT_DXT3, 11'd1, 11'd1, 64'hFFFF_0000_FFFF_0000, 64'h5555_AAAA_8410_FFFF,
      1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst;

  bctd_blk_if blk ();
  bctd_pix_if pix ();
  bctd_cfg_if cfg ();

  bc_texture_block_decoder DUT (
    .clk (clk),
    .rst (rst),
    .src (blk),
    .dst (pix),
    .cfg (cfg)
  );

  bctd_pkg::fmt_t             cur_fmt;
  logic [bctd_pkg::CFG_W-1:0] width_reg;
  logic [bctd_pkg::CFG_W-1:0] height_reg;
  logic [bctd_pkg::DIM_W-1:0] blk_col;
  logic [bctd_pkg::DIM_W-1:0] blk_row;
  pixel_t                     expected_pixels [$];
  int                         mismatches = 0;
  bit                         calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_bc_texture_block_decoder NOT OK");
    $finish;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < 15);
  endfunction

  function automatic int eff_dim(input logic [bctd_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > bctd_pkg::MAX_DIM_BLOCKS) return bctd_pkg::MAX_DIM_BLOCKS;
    return int'(v);
  endfunction

  function automatic void decode_block(input logic [63:0] fh, input logic [63:0] sh,
                                       input logic typed, input logic [31:0] rgba);
    logic [31:0] cword;
    logic [31:0] cidx;
    logic [47:0] abits;
    logic [15:0] e0;
    logic [15:0] e1;
    int          pal [4][4];
    int          apal [8];
    int          wd;
    int          ht;
    int          ci;
    int          a0;
    int          a1;
    bit          row_end;
    bit          img_end;
    bit          punch;
    pixel_t      p;
    wd = eff_dim(width_reg);
    ht = eff_dim(height_reg);
    row_end = int'(blk_col) >= wd - 1;
    img_end = row_end && (int'(blk_row) >= ht - 1);
    if (cur_fmt == bctd_pkg::FMT_DXT1) begin
      cword = fh[31:0];
      cidx = fh[63:32];
    end else begin
      cword = sh[31:0];
      cidx = sh[63:32];
    end
    e0 = cword[15:0];
    e1 = cword[31:16];
    punch = (cur_fmt == bctd_pkg::FMT_DXT1) && (e0 <= e1);
    pal[0][0] = int'({e0[4:0], 3'b000});
    pal[0][1] = int'({e0[10:5], 2'b00});
    pal[0][2] = int'({e0[15:11], 3'b000});
    pal[1][0] = int'({e1[4:0], 3'b000});
    pal[1][1] = int'({e1[10:5], 2'b00});
    pal[1][2] = int'({e1[15:11], 3'b000});
    for (int c = 0; c < 3; c++) begin
      if (punch) begin
        pal[2][c] = (pal[0][c] + pal[1][c]) / 2;
        pal[3][c] = 0;
      end else begin
        pal[2][c] = (2 * pal[0][c] + pal[1][c]) / 3;
        pal[3][c] = (pal[0][c] + 2 * pal[1][c]) / 3;
      end
    end
    for (int k = 0; k < 4; k++) pal[k][3] = 255;
    if (punch) pal[3][3] = 0;
    a0 = int'(fh[7:0]);
    a1 = int'(fh[15:8]);
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int z = 0; z < 6; z++) apal[z + 2] = ((6 - z) * a0 + (z + 1) * a1) / 7;
    end else begin
      for (int z = 0; z < 4; z++) apal[z + 2] = ((4 - z) * a0 + (z + 1) * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    abits = fh[63:16];
    for (int i = 0; i < bctd_pkg::PIX_PER_BLOCK; i++) begin
      ci = int'(cidx[2*i +: 2]);
      p.red = 8'(pal[ci][0]);
      p.green = 8'(pal[ci][1]);
      p.blue = 8'(pal[ci][2]);
      p.alpha = 8'(pal[ci][3]);
      case (cur_fmt)
        bctd_pkg::FMT_DXT3: p.alpha = 8'(int'(fh[4*i +: 4]) * 17);
        bctd_pkg::FMT_DXT5: p.alpha = 8'(apal[abits[3*i +: 3]]);
        bctd_pkg::FMT_DXTA: begin
          p.red = 8'(apal[abits[3*i +: 3]]);
          p.green = p.red;
          p.blue = p.red;
          p.alpha = bctd_pkg::ALPHA_OPAQUE;
        end
        default: ;
      endcase
      if (typed) {p.red, p.green, p.blue, p.alpha} = rgba;
      p.px = bctd_pkg::PIX_W'(int'(blk_col) * 4 + i % 4);
      p.py = bctd_pkg::PIX_W'(int'(blk_row) * 4 + i / 4);
      p.last_blk = (i == bctd_pkg::PIX_PER_BLOCK - 1);
      p.last_img = (i == bctd_pkg::PIX_PER_BLOCK - 1) && img_end;
      expected_pixels.push_back(p);
    end
    if (row_end) begin
      blk_col = '0;
      blk_row = (int'(blk_row) >= ht - 1) ? '0 : blk_row + bctd_pkg::DIM_W'(1);
    end else begin
      blk_col = blk_col + bctd_pkg::DIM_W'(1);
    end
  endfunction

  task automatic send_block(input logic [63:0] fh, input logic [63:0] sh,
                            input logic typed, input logic [31:0] rgba);
    @(negedge clk);
    while (roll_idle()) begin
      blk.valid <= 1'b0;
      @(negedge clk);
    end
    blk.valid <= 1'b1;
    blk.first_half <= fh;
    blk.second_half <= sh;
    @(posedge clk);
    while (!blk.ready) @(posedge clk);
    decode_block(fh, sh, typed, rgba);
  endtask

  task automatic drain();
    @(negedge clk);
    blk.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bctd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bctd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      bctd_pkg::REG_FORMAT: cur_fmt = bctd_pkg::fmt_t'(val[1:0]);
      bctd_pkg::REG_WIDTH:  width_reg = val;
      bctd_pkg::REG_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: pixel expected none actual (%0d,%0d)", $time, pix.pixel_x,
               pix.pixel_y);
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      check_field("red", want.red, pix.red);
      check_field("green", want.green, pix.green);
      check_field("blue", want.blue, pix.blue);
      check_field("alpha", want.alpha, pix.alpha);
      check_field("pixel_x", want.px, pix.pixel_x);
      check_field("pixel_y", want.py, pix.pixel_y);
      check_field("last_of_block", want.last_blk, pix.last_of_block);
      check_field("last_of_image", want.last_img, pix.last_of_image);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready) check_pixel();
  end

  initial begin
    pix.ready = 1'b0;
    forever begin
      @(negedge clk);
      pix.ready <= !rst && !roll_idle();
    end
  end

  initial begin
    logic [63:0]                fh;
    logic [63:0]                sh;
    logic [bctd_pkg::CFG_W-1:0] dim;
    int                         n_blocks;
    int                         hold_at;
    rst = 1'b1;
    blk.valid = 1'b0;
    blk.first_half = '0;
    blk.second_half = '0;
    cfg.valid = 1'b0;
    cfg.index = bctd_pkg::REG_FORMAT;
    cfg.data = '0;
    cur_fmt = bctd_pkg::FMT_DXT1;
    width_reg = bctd_pkg::CFG_W'(1);
    height_reg = bctd_pkg::CFG_W'(1);
    blk_col = '0;
    blk_row = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++) begin
      if (BLOCK_TABLE[r].fmt != cur_fmt || BLOCK_TABLE[r].wdt != width_reg ||
          BLOCK_TABLE[r].hgt != height_reg) begin
        drain();
        if (BLOCK_TABLE[r].fmt != cur_fmt)
          write_reg(bctd_pkg::REG_FORMAT, bctd_pkg::CFG_W'(BLOCK_TABLE[r].fmt));
        if (BLOCK_TABLE[r].wdt != width_reg)
          write_reg(bctd_pkg::REG_WIDTH, BLOCK_TABLE[r].wdt);
        if (BLOCK_TABLE[r].hgt != height_reg)
          write_reg(bctd_pkg::REG_HEIGHT, BLOCK_TABLE[r].hgt);
      end
      send_block(BLOCK_TABLE[r].fh, BLOCK_TABLE[r].sh, BLOCK_TABLE[r].typed,
                 BLOCK_TABLE[r].rgba);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      calm = (ph == 3);
      write_reg(bctd_pkg::REG_FORMAT, bctd_pkg::CFG_W'($urandom_range(0, 2047)));
      for (int d = 0; d < 2; d++) begin
        case ($urandom_range(0, 7))
          0: dim = '0;
          1: dim = bctd_pkg::CFG_W'(1);
          2: dim = bctd_pkg::CFG_W'(bctd_pkg::MAX_DIM_BLOCKS);
          3: dim = bctd_pkg::CFG_W'($urandom_range(bctd_pkg::MAX_DIM_BLOCKS + 1, 2047));
          default: dim = bctd_pkg::CFG_W'($urandom_range(2, 6));
        endcase
        if ($urandom_range(0, 3) != 0)
          write_reg(d == 0 ? bctd_pkg::REG_WIDTH : bctd_pkg::REG_HEIGHT, dim);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_SPARE, bctd_pkg::CFG_W'($urandom_range(0, 2047)));
      n_blocks = $urandom_range(30, 45);
      hold_at = $urandom_range(1, n_blocks - 1);
      for (int k = 0; k < n_blocks; k++) begin
        // pause the sender until the decoder has emptied
        if (k == hold_at) drain();
        fh = {$urandom, $urandom};
        sh = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0: begin
            fh[31:16] = fh[15:0];
            sh[31:16] = sh[15:0];
          end
          1: fh[15:8] = fh[7:0];
          default: ;
        endcase
        send_block(fh, sh, 1'b0, 32'h0);
      end
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bc_texture_block_decoder OK");
    end else begin
      $display("tb_bc_texture_block_decoder NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
